>>> hdl/dfu_pkg.sv
// types, codes and constants shared by the dfu request state machine
package dfu_pkg;

   typedef enum logic [3:0] {
      ST_APP_IDLE        = 4'd0,
      ST_APP_DETACH      = 4'd1,
      ST_IDLE            = 4'd2,
      ST_DN_SYNC         = 4'd3,
      ST_DN_BUSY         = 4'd4,
      ST_DN_IDLE         = 4'd5,
      ST_MAN_SYNC        = 4'd6,
      ST_MAN             = 4'd7,
      ST_MAN_WAIT_RESET  = 4'd8,
      ST_UP_IDLE         = 4'd9,
      ST_ERROR           = 4'd10
   } dfu_state_type;

   typedef enum logic [2:0] {
      ACT_SETUP         = 3'd0,
      ACT_UPLOAD_DONE   = 3'd1,
      ACT_DNLOAD_DONE   = 3'd2,
      ACT_MANIFEST_DONE = 3'd3,
      ACT_RESUME        = 3'd4
   } dfu_action_type;

   typedef enum logic [3:0] {
      KIND_NONE       = 4'd0,
      KIND_ACK        = 4'd1,
      KIND_STALL      = 4'd2,
      KIND_STATE      = 4'd3,
      KIND_STATUS     = 4'd4,
      KIND_UP_FETCH   = 4'd5,
      KIND_OUT_ACCEPT = 4'd6,
      KIND_DN_WRITE   = 4'd7,
      KIND_MAN_START  = 4'd8
   } dfu_kind_type;

   localparam logic [7:0] REQ_DETACH    = 8'd0;
   localparam logic [7:0] REQ_DNLOAD    = 8'd1;
   localparam logic [7:0] REQ_UPLOAD    = 8'd2;
   localparam logic [7:0] REQ_GETSTATUS = 8'd3;
   localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
   localparam logic [7:0] REQ_GETSTATE  = 8'd5;
   localparam logic [7:0] REQ_ABORT     = 8'd6;

   // class request to an interface, direction bit masked off
   localparam logic [6:0] REQ_TYPE_CLASS_IFACE = 7'h21;

   localparam logic [3:0] STATUS_OK         = 4'd0;
   localparam logic [3:0] STATUS_STALLEDPKT = 4'd15;

   localparam logic [1:0] CSR_INTERFACE_NUMBER = 2'd0;
   localparam logic [1:0] CSR_POLL_TIMEOUT     = 2'd1;
   localparam logic [1:0] CSR_MANIFEST_PRESENT = 2'd2;

   localparam logic [15:0] POLL_TIMEOUT_RESET = 16'd10;
   localparam logic [15:0] STATE_BYTE_LEN     = 16'd1;
   localparam logic [15:0] STATUS_BLOCK_LEN   = 16'd6;

   typedef struct packed {
      dfu_kind_type reply_kind;
      logic [3:0]   status_code;
      logic [3:0]   state_code;
      logic [15:0]  timeout_ms;
      logic [31:0]  transfer_offset;
      logic [15:0]  transfer_length;
   } dfu_result_type;

   // all results of one event, handed from front to back
   typedef struct packed {
      logic           two;
      dfu_result_type res0;
      dfu_result_type res1;
   } dfu_record_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic not_empty;
   } dfu_queue_stat_type;

endpackage

>>> hdl/dfu_req_if.sv
// request channel: setup packets and completion events
interface dfu_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  request_type;
   logic [7:0]  request_code;
   logic [15:0] request_value;
   logic [15:0] request_index;
   logic [15:0] request_length;
   logic [3:0]  firmware_status;
   logic [15:0] returned_length;

   modport source (output valid, action, request_type, request_code, request_value,
                   request_index, request_length, firmware_status, returned_length,
                   input ready);
   modport sink (input valid, action, request_type, request_code, request_value,
                 request_index, request_length, firmware_status, returned_length,
                 output ready);
endinterface

>>> hdl/dfu_rsp_if.sv
// response channel: replies and firmware data commands
interface dfu_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  reply_kind;
   logic [3:0]  status_code;
   logic [3:0]  state_code;
   logic [15:0] timeout_ms;
   logic [31:0] transfer_offset;
   logic [15:0] transfer_length;
   logic        last;

   modport source (output valid, reply_kind, status_code, state_code, timeout_ms,
                   transfer_offset, transfer_length, last, input ready);
   modport sink (input valid, reply_kind, status_code, state_code, timeout_ms,
                 transfer_offset, transfer_length, last, output ready);
endinterface

>>> hdl/usb_dfu_request_state_machine_unit.sv
// top level of the usb dfu 1.1 device request state machine
//
// req_ch takes one event per beat: a dfu class setup request (action 0) or the
// completion of an upload, download or manifest step, or the resume point of a
// held-back getstatus. rsp_ch returns zero, one or two results per event; the
// last result of an event has last set. csr_* writes interface_number (0),
// poll_timeout (1) and manifest_present (2); the user must write them only
// while the block is idle, which the block leaves unchecked. Each event is
// decoded and the dfu state updated in the cycle it is taken, so req_ch
// accepts one event per cycle while the queue has room. The record of results
// enters a queue of QUEUE_DEPTH entries and passes from the queue head into
// the output register, which shows its first result. Two-result events take
// two rsp beats, which sets the drain rate at rsp_ch. When rsp_ch stalls, the
// queue absorbs up to QUEUE_DEPTH further events and ready then drops until the
// output side drains. Events that produce no result never occupy the queue.
// Reset (synchronous) puts the device in appIDLE with status ok, clears offset,
// length and flags, sets poll_timeout to 10 and empties queue and output.
module usb_dfu_request_state_machine_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   dfu_req_if.sink     req_ch,
   dfu_rsp_if.source   rsp_ch,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import dfu_pkg::*;

   logic               push, pop;
   dfu_record_type     push_rec, head_rec;
   dfu_queue_stat_type q_stat;

   dfu_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .q_stat         (q_stat),
      .push           (push),
      .push_rec       (push_rec)
   );

   dfu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .stat     (q_stat)
   );

   dfu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_rec (head_rec),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

>>> hdl/dfu_front.sv
// front end: csr registers, request decode and dfu state update
module dfu_front (
   input  logic                    clock,
   input  logic                    reset,
   dfu_req_if.sink                 req_ch,
   input  logic                    csr_write_en,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_write_data,
   input  dfu_pkg::dfu_queue_stat_type q_stat,
   output logic                    push,
   output dfu_pkg::dfu_record_type push_rec
);
   import dfu_pkg::*;

   logic [7:0]    iface_num_ff;
   logic [15:0]   poll_ff;
   logic          man_present_ff;

   dfu_state_type state_ff, state_in;
   logic [3:0]    status_ff, status_in;
   logic [31:0]   offset_ff, offset_in;
   logic [15:0]   length_ff, length_in;
   logic          pending_ff, pending_in;
   logic          deferred_ff, deferred_in;

   logic           accept;
   logic           run_setup;
   logic [1:0]     cnt;
   logic [1:0]     scnt;
   dfu_result_type r0, r1, s0, s1;
   logic           dir_in;
   logic [15:0]    iface;
   logic           to_man;
   dfu_state_type  st_after;
   logic [3:0]     man_st;
   logic [31:0]    off_v;
   logic           abort_ok;

   assign req_ch.ready = !q_stat.full;
   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         iface_num_ff   <= '0;
         poll_ff        <= POLL_TIMEOUT_RESET;
         man_present_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_INTERFACE_NUMBER: iface_num_ff <= csr_write_data[7:0];
            CSR_POLL_TIMEOUT:     poll_ff <= csr_write_data;
            CSR_MANIFEST_PRESENT: man_present_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_APP_IDLE;
         status_ff   <= STATUS_OK;
         offset_ff   <= '0;
         length_ff   <= '0;
         pending_ff  <= 1'b0;
         deferred_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         status_ff   <= status_in;
         offset_ff   <= offset_in;
         length_ff   <= length_in;
         pending_ff  <= pending_in;
         deferred_ff <= deferred_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      offset_in   = offset_ff;
      length_in   = length_ff;
      pending_in  = pending_ff;
      deferred_in = deferred_ff;
      r0          = '0;
      r1          = '0;
      s0          = '0;
      s1          = '0;
      cnt         = 2'd0;
      scnt        = 2'd0;
      run_setup   = 1'b0;
      to_man      = 1'b0;
      st_after    = state_ff;
      man_st      = STATUS_OK;
      off_v       = offset_ff;
      dir_in      = req_ch.request_type[7];
      iface       = (state_ff > ST_APP_DETACH) ? 16'd0 : {8'd0, iface_num_ff};
      abort_ok    = (state_ff == ST_IDLE) || (state_ff == ST_DN_SYNC) ||
                    (state_ff == ST_DN_IDLE) || (state_ff == ST_MAN_SYNC) ||
                    (state_ff == ST_UP_IDLE);

      if (accept) begin
         unique case (req_ch.action)
            ACT_SETUP: run_setup = 1'b1;
            ACT_UPLOAD_DONE: begin
               if (pending_ff && state_ff == ST_UP_IDLE) begin
                  cnt        = 2'd1;
                  pending_in = 1'b0;
                  if (req_ch.firmware_status != STATUS_OK) begin
                     status_in     = req_ch.firmware_status;
                     state_in      = ST_ERROR;
                     r0.reply_kind = KIND_STALL;
                  end else begin
                     status_in          = STATUS_OK;
                     r0.reply_kind      = KIND_ACK;
                     r0.transfer_length = req_ch.returned_length;
                     // a short upload ends the transfer
                     if (req_ch.returned_length < length_ff) state_in = ST_IDLE;
                     length_in = req_ch.returned_length;
                     offset_in = offset_ff + {16'd0, req_ch.returned_length};
                  end
               end
            end
            ACT_DNLOAD_DONE: begin
               if (pending_ff && state_ff == ST_DN_BUSY) begin
                  pending_in = 1'b0;
                  if (req_ch.firmware_status != STATUS_OK) begin
                     cnt           = 2'd1;
                     status_in     = req_ch.firmware_status;
                     state_in      = ST_ERROR;
                     r0.reply_kind = KIND_STALL;
                  end else begin
                     status_in = STATUS_OK;
                     offset_in = offset_ff + {16'd0, length_ff};
                     state_in  = ST_DN_IDLE;
                  end
               end
            end
            ACT_MANIFEST_DONE: begin
               if (pending_ff && state_ff == ST_MAN) begin
                  man_st     = man_present_ff ? req_ch.firmware_status : STATUS_OK;
                  pending_in = 1'b0;
                  if (man_st != STATUS_OK) begin
                     cnt           = 2'd1;
                     status_in     = man_st;
                     state_in      = ST_ERROR;
                     r0.reply_kind = KIND_STALL;
                  end else begin
                     status_in = STATUS_OK;
                     state_in  = ST_IDLE;
                  end
               end
            end
            ACT_RESUME: begin
               if (pending_ff && deferred_ff &&
                   (state_ff == ST_DN_SYNC || state_ff == ST_MAN_SYNC)) begin
                  if (state_ff == ST_DN_SYNC) begin
                     cnt                = 2'd1;
                     r0.reply_kind      = KIND_DN_WRITE;
                     r0.transfer_offset = offset_ff;
                     r0.transfer_length = length_ff;
                  end
                  // the held-back request is answered now
                  run_setup = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (run_setup) begin
         scnt = 2'd1;
         if (req_ch.request_type[6:0] != REQ_TYPE_CLASS_IFACE ||
             req_ch.request_index != iface) begin
            s0.reply_kind = KIND_NONE;
         end else if (!dir_in && req_ch.request_code == REQ_DETACH &&
                      req_ch.request_length == 16'd0 && state_ff == ST_APP_IDLE) begin
            state_in      = ST_APP_DETACH;
            s0.reply_kind = KIND_ACK;
         end else if (dir_in && req_ch.request_code == REQ_GETSTATE &&
                      req_ch.request_value == 16'd0 &&
                      req_ch.request_length == STATE_BYTE_LEN) begin
            s0.reply_kind      = KIND_STATE;
            s0.state_code      = state_ff;
            s0.transfer_length = STATE_BYTE_LEN;
         end else if (dir_in && req_ch.request_code == REQ_GETSTATUS &&
                      req_ch.request_value == 16'd0 &&
                      req_ch.request_length == STATUS_BLOCK_LEN) begin
            if ((state_ff == ST_DN_SYNC || state_ff == ST_MAN_SYNC) && !deferred_ff) begin
               deferred_in = 1'b1;
               scnt        = 2'd0;
            end else begin
               if (state_ff == ST_DN_SYNC) begin
                  st_after = ST_DN_BUSY;
               end else if (state_ff == ST_MAN_SYNC) begin
                  st_after = ST_MAN;
                  to_man   = 1'b1;
               end
               state_in           = st_after;
               s0.reply_kind      = KIND_STATUS;
               s0.status_code     = status_ff;
               s0.state_code      = st_after;
               s0.timeout_ms      = poll_ff;
               s0.transfer_length = STATUS_BLOCK_LEN;
               if (to_man && pending_ff) begin
                  if (man_present_ff) begin
                     s1.reply_kind = KIND_MAN_START;
                     scnt          = 2'd2;
                  end else begin
                     status_in  = STATUS_OK;
                     state_in   = ST_IDLE;
                     pending_in = 1'b0;
                  end
               end
            end
         end else if (!dir_in && req_ch.request_code == REQ_CLRSTATUS &&
                      req_ch.request_value == 16'd0 && req_ch.request_length == 16'd0 &&
                      state_ff == ST_ERROR) begin
            status_in     = STATUS_OK;
            state_in      = ST_IDLE;
            s0.reply_kind = KIND_ACK;
         end else if (dir_in && req_ch.request_code == REQ_UPLOAD &&
                      (state_ff == ST_IDLE || state_ff == ST_UP_IDLE)) begin
            if (state_ff == ST_IDLE) begin
               state_in  = ST_UP_IDLE;
               offset_in = '0;
               off_v     = '0;
            end
            length_in          = req_ch.request_length;
            pending_in         = 1'b1;
            s0.reply_kind      = KIND_UP_FETCH;
            s0.transfer_offset = off_v;
            s0.transfer_length = req_ch.request_length;
         end else if (!dir_in && req_ch.request_code == REQ_DNLOAD &&
                      (state_ff == ST_IDLE ||
                       (state_ff == ST_DN_IDLE && req_ch.request_length != 16'd0))) begin
            if (state_ff == ST_IDLE) begin
               offset_in = '0;
               off_v     = '0;
            end
            state_in           = ST_DN_SYNC;
            length_in          = req_ch.request_length;
            pending_in         = 1'b1;
            deferred_in        = 1'b0;
            s0.reply_kind      = KIND_OUT_ACCEPT;
            s0.transfer_offset = off_v;
            s0.transfer_length = req_ch.request_length;
         end else if (!dir_in && req_ch.request_code == REQ_DNLOAD &&
                      state_ff == ST_DN_IDLE) begin
            // zero-length download closes the image
            state_in      = ST_MAN_SYNC;
            pending_in    = 1'b1;
            deferred_in   = 1'b0;
            s0.reply_kind = KIND_ACK;
         end else if (!dir_in && req_ch.request_code == REQ_ABORT &&
                      req_ch.request_value == 16'd0 && req_ch.request_length == 16'd0 &&
                      abort_ok) begin
            state_in      = ST_IDLE;
            s0.reply_kind = KIND_ACK;
         end else begin
            status_in     = STATUS_STALLEDPKT;
            state_in      = ST_ERROR;
            pending_in    = 1'b0;
            s0.reply_kind = KIND_STALL;
         end

         // merge behind a download write already in slot zero
         if (cnt == 2'd0) begin
            r0  = s0;
            r1  = s1;
            cnt = scnt;
         end else if (scnt != 2'd0) begin
            r1  = s0;
            cnt = 2'd2;
         end
      end
   end

   assign push          = accept && (cnt != 2'd0);
   assign push_rec.two  = (cnt == 2'd2);
   assign push_rec.res0 = r0;
   assign push_rec.res1 = r1;

endmodule

>>> hdl/dfu_queue.sv
// short record queue between front and back
module dfu_queue #(
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  dfu_pkg::dfu_record_type     push_rec,
   input  logic                        pop,
   output dfu_pkg::dfu_record_type     head_rec,
   output dfu_pkg::dfu_queue_stat_type stat
);
   import dfu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dfu_record_type    slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign do_push        = push && !stat.full;
   assign do_pop         = pop && stat.not_empty;
   assign head_rec       = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

>>> hdl/dfu_back.sv
// back end: output register, sends the one or two results of each record
module dfu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  dfu_pkg::dfu_record_type     head_rec,
   input  dfu_pkg::dfu_queue_stat_type q_stat,
   output logic                        pop,
   dfu_rsp_if.source                   rsp_ch
);
   import dfu_pkg::*;

   logic           valid_ff, valid_in;
   logic           phase_ff, phase_in;
   dfu_record_type rec_ff;
   dfu_result_type cur;
   logic           finishing;
   logic           beat;

   assign finishing = phase_ff || !rec_ff.two;
   assign beat      = valid_ff && rsp_ch.ready;
   assign pop       = q_stat.not_empty && (!valid_ff || (beat && finishing));

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (beat && !finishing) begin
         phase_in = 1'b1;
      end else if (!valid_ff || beat) begin
         valid_in = q_stat.not_empty;
         phase_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) rec_ff <= head_rec;
   end

   assign cur                    = phase_ff ? rec_ff.res1 : rec_ff.res0;
   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.reply_kind      = cur.reply_kind;
   assign rsp_ch.status_code     = cur.status_code;
   assign rsp_ch.state_code      = cur.state_code;
   assign rsp_ch.timeout_ms      = cur.timeout_ms;
   assign rsp_ch.transfer_offset = cur.transfer_offset;
   assign rsp_ch.transfer_length = cur.transfer_length;
   assign rsp_ch.last            = finishing;

endmodule

>>> hdl/dfu_checker.sv
// port-level checks for the dfu request state machine, bound to the top level
module dfu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_reply_kind,
   input logic [31:0] rsp_transfer_offset,
   input logic        rsp_last
);
   import dfu_pkg::*;

   // output side is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reply_kind) &&
      $stable(rsp_transfer_offset) && $stable(rsp_last))
      else $error("stalled response changed");

   // only a download write or a status block can lead a pair
   a_pair_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |->
      rsp_reply_kind == KIND_DN_WRITE || rsp_reply_kind == KIND_STATUS)
      else $error("unexpected first result of a pair");

   // second result of a pair follows in the next cycle
   a_pair_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("second result of a pair missing");

   a_status_then_manifest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last && rsp_reply_kind == KIND_STATUS |=>
      rsp_reply_kind == KIND_MAN_START && rsp_last)
      else $error("status block pair without manifest start");

endmodule

bind usb_dfu_request_state_machine_unit dfu_checker u_dfu_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_reply_kind      (rsp_ch.reply_kind),
   .rsp_transfer_offset (rsp_ch.transfer_offset),
   .rsp_last            (rsp_ch.last)
);
